// ===== hdl/qcrl_pkg.sv =====
// Shared types and constants of the QPSK carrier recovery loop.
// Holds the controller states, the datapath command, and the fixed tables.
`timescale 1ns / 1ps

package qcrl_pkg;

    localparam int unsigned TANH_TABLE_DEPTH = 32;
    localparam int unsigned TANH_IW = $clog2(TANH_TABLE_DEPTH);

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;
    localparam logic [63:0] SIN_DIVS [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    localparam logic [30:0] ONE_RAD_UNITS = 31'd683565276;
    localparam logic [30:0] FREQ_LIMIT_RESET = 31'd205069583;
    localparam logic [31:0] AVG_RESET = 32'd1000 << 16;
    localparam logic [31:0] LOCK_ON_Q16 = 32'd85 << 16;
    localparam logic [31:0] LOCK_OFF_Q16 = 32'd105 << 16;
    localparam logic [10:0] POLE_Q20 = 11'd1049;
    localparam logic [19:0] POLE_KEEP_Q20 = 20'd1047527;
    localparam logic [9:0] SWEEP_STEP = 10'd684;

    localparam logic [1:0] CFG_ALPHA = 2'd0;
    localparam logic [1:0] CFG_BETA = 2'd1;
    localparam logic [1:0] CFG_LIMIT = 2'd2;
    localparam logic [1:0] CFG_OQPSK = 2'd3;

    localparam logic OPC_MIX = 1'b0;
    localparam logic OPC_UPDATE = 1'b1;

    localparam logic signed [16:0] TANH_Q15 [TANH_TABLE_DEPTH] = '{
        -17'sd32768, -17'sd32768, -17'sd32768, -17'sd32768,
        -17'sd32768, -17'sd32768, -17'sd32768, -17'sd32768,
        -17'sd32768, -17'sd32768, -17'sd32768, -17'sd32765,
        -17'sd32746, -17'sd32606, -17'sd31589, -17'sd24956,
        17'sd0, 17'sd24956, 17'sd31589, 17'sd32606,
        17'sd32746, 17'sd32765, 17'sd32768, 17'sd32768,
        17'sd32768, 17'sd32768, 17'sd32768, 17'sd32768,
        17'sd32768, 17'sd32768, 17'sd32768, 17'sd32768
    };

    typedef enum logic [4:0] {
        S_IDLE, S_SIDX, S_SRD, S_CRD, S_MRE1, S_MRE2, S_MIM1, S_MIM2, S_MFIN,
        S_TANH, S_ERR1, S_ERR2, S_PLO, S_PHI, S_PAPPLY, S_FHI, S_FSUM,
        S_AVG, S_LOCK, S_CLAMP
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_SIDX, OP_SRD, OP_CRD, OP_MRE1, OP_MRE2, OP_MIM1, OP_MIM2,
        OP_MFIN, OP_TANH, OP_ERR1, OP_ERR2, OP_PLO, OP_PHI, OP_PAPPLY, OP_FHI,
        OP_FSUM, OP_AVG, OP_LOCK, OP_CLAMP
    } dp_op_t;

    typedef struct packed {
        logic   load_input;
        dp_op_t op;
    } dp_cmd_t;

endpackage

// ===== hdl/qpsk_carrier_recovery_loop.sv =====
// Top level of the QPSK / offset QPSK Costas carrier recovery loop.
// Joins qcrl_ctrl and qcrl_datapath; uses qcrl_pkg for the command type.
`timescale 1ns / 1ps
//
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------------
// input    | in_valid / in_stall  | opcode, sample_re, sample_im, cosample_im
// output   | out_valid / out_stall| mixed_re, mixed_im, freq_estimate, locked, locked_once
// config   | cfg_write            | cfg_index, cfg_data
//
// Mix and update transfers each run their own sequence of steps from acceptance to the
// result, through the shared datapath multipliers and the sine ROM port.
// A new item is accepted in the cycle after the previous result enters the output register,
// even while that result still waits to be taken.
// Reset is asynchronous and active low and needs no clearing pass; the sine ROM is constant.
// When the output stalls with a result pending, the next item stops at its last step.
//
// Mix rotates the sample by minus the loop phase through the sine ROM, rounds and saturates,
// and then advances the phase by the frequency. Update forms the tanh-weighted phase error,
// corrects phase and frequency by the two gains, tracks a leaky average of the error
// magnitude for lock detection with hysteresis, sweeps the frequency while unlocked, and
// clamps the frequency to the configured limit (halved in offset QPSK mode).

module qpsk_carrier_recovery_loop
    import qcrl_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           opcode,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_re,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_im,
    input  logic signed [SAMPLE_WIDTH-1:0] cosample_im,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] mixed_re,
    output logic signed [SAMPLE_WIDTH-1:0] mixed_im,
    output logic signed [31:0]             freq_estimate,
    output logic                           locked,
    output logic                           locked_once,
    input  logic                           cfg_write,
    input  logic [1:0]                     cfg_index,
    input  logic [31:0]                    cfg_data
);

    dp_cmd_t cmd;

    // The controller walks the steps of each item and owns both handshakes.
    qcrl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .opcode    (opcode),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // The datapath holds the loop state, the configuration and the output register.
    qcrl_datapath #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .SAMPLE_WIDTH     (SAMPLE_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample_re     (sample_re),
        .sample_im     (sample_im),
        .cosample_im   (cosample_im),
        .mixed_re      (mixed_re),
        .mixed_im      (mixed_im),
        .freq_estimate (freq_estimate),
        .locked        (locked),
        .locked_once   (locked_once)
    );

endmodule

// ===== hdl/qcrl_ctrl.sv =====
// Sequencer of the carrier loop: one state per datapath step.
// Depends on qcrl_pkg for the state and command types.
`timescale 1ns / 1ps

module qcrl_ctrl
    import qcrl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    opcode,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.load_input = 1'b0;
        cmd.op = OP_NONE;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_input = 1'b1;
                    state_next = (opcode == OPC_UPDATE) ? S_TANH : S_SIDX;
                end
            end
            S_SIDX:   begin cmd.op = OP_SIDX;   state_next = S_SRD;    end
            S_SRD:    begin cmd.op = OP_SRD;    state_next = S_CRD;    end
            S_CRD:    begin cmd.op = OP_CRD;    state_next = S_MRE1;   end
            S_MRE1:   begin cmd.op = OP_MRE1;   state_next = S_MRE2;   end
            S_MRE2:   begin cmd.op = OP_MRE2;   state_next = S_MIM1;   end
            S_MIM1:   begin cmd.op = OP_MIM1;   state_next = S_MIM2;   end
            S_MIM2:   begin cmd.op = OP_MIM2;   state_next = S_MFIN;   end
            S_TANH:   begin cmd.op = OP_TANH;   state_next = S_ERR1;   end
            S_ERR1:   begin cmd.op = OP_ERR1;   state_next = S_ERR2;   end
            S_ERR2:   begin cmd.op = OP_ERR2;   state_next = S_PLO;    end
            S_PLO:    begin cmd.op = OP_PLO;    state_next = S_PHI;    end
            S_PHI:    begin cmd.op = OP_PHI;    state_next = S_PAPPLY; end
            S_PAPPLY: begin cmd.op = OP_PAPPLY; state_next = S_FHI;    end
            S_FHI:    begin cmd.op = OP_FHI;    state_next = S_FSUM;   end
            S_FSUM:   begin cmd.op = OP_FSUM;   state_next = S_AVG;    end
            S_AVG:    begin cmd.op = OP_AVG;    state_next = S_LOCK;   end
            S_LOCK:   begin cmd.op = OP_LOCK;   state_next = S_CLAMP;  end
            S_MFIN, S_CLAMP:
            begin
                // The last step commits state, so it waits for a free output register.
                if (out_free)
                begin
                    cmd.op = (state_reg == S_MFIN) ? OP_MFIN : OP_CLAMP;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

endmodule

// ===== hdl/qcrl_datapath.sv =====
// Datapath of the carrier loop: sine ROM, multipliers, loop state and output register.
// Depends on qcrl_pkg for the command type, tables and constants.
`timescale 1ns / 1ps

module qcrl_datapath
    import qcrl_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  dp_cmd_t                        cmd,
    input  logic                           cfg_write,
    input  logic [1:0]                     cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_re,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_im,
    input  logic signed [SAMPLE_WIDTH-1:0] cosample_im,
    output logic signed [SAMPLE_WIDTH-1:0] mixed_re,
    output logic signed [SAMPLE_WIDTH-1:0] mixed_im,
    output logic signed [31:0]             freq_estimate,
    output logic                           locked,
    output logic                           locked_once
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int IW = $clog2(SINE_TABLE_DEPTH);
    localparam int AW = SW + 18;
    localparam int EW = SW + 18;
    localparam int MW = EW + 32;
    localparam int FW = (SW + 21 > 34) ? SW + 21 : 34;
    localparam logic signed [AW-1:0] SMAX = AW'((2 ** (SW - 1)) - 1);
    localparam logic signed [AW-1:0] SMIN = -SMAX - AW'(1);
    localparam logic signed [SW-1:0] T_HI = SW'(15);
    localparam logic signed [SW-1:0] T_LO = -SW'(16);

    typedef logic signed [16:0] sine_rom_t [SINE_TABLE_DEPTH];

    function automatic sine_rom_t build_sine();
        sine_rom_t rom;
        logic [63:0] u, quad, rem, x, x2, h, p, q;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            u = 64'(k) * 64'd4;
            quad = u / SINE_TABLE_DEPTH;
            rem = u % SINE_TABLE_DEPTH;
            x = (rem * PI_HALF_Q30) / SINE_TABLE_DEPTH;
            if (quad[0])
                x = PI_HALF_Q30 - x;
            x2 = (x * x) >> 30;
            h = ONE_Q30;
            for (int i = 0; i < 5; i++)
                h = ONE_Q30 - (((x2 * h) >> 30) / SIN_DIVS[i]);
            p = (x * h) >> 30;
            q = (p + 64'd16384) >> 15;
            rom[k] = quad[1] ? -17'(q) : 17'(q);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine();

    function automatic logic signed [16:0] tanh_of(input logic signed [SW-1:0] v);
        logic [TANH_IW-1:0] ix;
        ix = {~v[TANH_IW-1], v[TANH_IW-2:0]};
        if (v > T_HI)
            return 17'sd32768;
        else if (v < T_LO)
            return -17'sd32768;
        else
            return TANH_Q15[ix];
    endfunction

    // Round from Q15 half away from zero, then saturate to the sample width.
    function automatic logic signed [SW-1:0] round_sat(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] r;
        r = (v + (v[AW-1] ? AW'(16383) : AW'(16384))) >>> 15;
        if (r > SMAX)
            return SMAX[SW-1:0];
        else if (r < SMIN)
            return SMIN[SW-1:0];
        else
            return r[SW-1:0];
    endfunction

    // Configuration and loop state.
    logic [31:0]        alpha_reg, beta_reg;
    logic [30:0]        limit_reg;
    logic               oqpsk_reg;
    logic [31:0]        phase_reg, phase_next;
    logic signed [31:0] freq_reg;
    logic [31:0]        avg_reg, avg_next;
    logic               lock_reg, lock_next, seen_reg, sweep_down_reg;

    // Working registers.
    logic signed [SW-1:0]   re_reg, im_reg, cq_reg;
    logic [IW-1:0]          idx_reg;
    logic signed [16:0]     rom_q_reg, s_reg, c_reg, t_re_reg, t_cq_reg;
    logic signed [AW-1:0]   acc_re_reg, acc_im_reg;
    logic signed [SW+16:0]  prod_reg;
    logic signed [EW-1:0]   e_reg;
    logic [MW-1:0]          m_reg;
    logic signed [FW-1:0]   f_reg;
    logic [51:0]            avg_prod_reg;

    // Output register.
    logic signed [SW-1:0]   mixed_re_reg, mixed_im_reg;
    logic signed [31:0]     freq_out_reg;
    logic                   locked_reg, locked_once_reg;

    // Combinational helpers.
    logic [31:0]            idx_src;
    logic [63:0]            idx_prod;
    logic signed [SW+16:0]  mul_a, mul_b;
    logic                   e_neg;
    logic [EW-1:0]          e_mag;
    logic [15:0]            gain_half;
    logic [EW+15:0]         g_prod;
    logic [MW-1:0]          m_round;
    logic [EW:0]            rnd;
    logic signed [FW-1:0]   rnd_s, f_sum;
    logic [EW:0]            e2;
    logic [31:0]            ae32;
    logic [42:0]            ae_w;
    logic [52:0]            avg_sum;
    logic [32:0]            avg_shift;
    logic [30:0]            lim_cap, lim;
    logic signed [FW-1:0]   lim_s;
    logic signed [FW-1:0]   f_clamped;

    assign idx_src = (cmd.op == OP_SIDX) ? phase_reg : phase_reg + 32'h4000_0000;
    assign idx_prod = 64'(idx_src) * 64'(SINE_TABLE_DEPTH);

    always_comb
    begin
        mul_a = re_reg * rom_q_reg;
        mul_b = im_reg * s_reg;
        case (cmd.op)
            OP_MRE1: begin mul_a = re_reg * rom_q_reg;  mul_b = im_reg * rom_q_reg; end
            OP_MRE2: begin mul_a = im_reg * s_reg;      mul_b = re_reg * s_reg;     end
            OP_MIM1: begin mul_a = im_reg * c_reg;      mul_b = im_reg * c_reg;     end
            OP_MIM2: begin mul_a = re_reg * s_reg;      mul_b = re_reg * s_reg;     end
            OP_ERR1: begin mul_a = t_re_reg * cq_reg;   mul_b = t_re_reg * cq_reg;  end
            OP_ERR2: begin mul_a = t_cq_reg * re_reg;   mul_b = t_cq_reg * re_reg;  end
            default: begin mul_a = re_reg * rom_q_reg;  mul_b = im_reg * s_reg;     end
        endcase
    end

    assign e_neg = e_reg[EW-1];
    assign e_mag = e_neg ? EW'(-e_reg) : EW'(e_reg);

    always_comb
    begin
        case (cmd.op)
            OP_PLO:    gain_half = alpha_reg[15:0];
            OP_PHI:    gain_half = alpha_reg[31:16];
            OP_PAPPLY: gain_half = beta_reg[15:0];
            default:   gain_half = beta_reg[31:16];
        endcase
    end

    assign g_prod = gain_half * e_mag;
    assign m_round = m_reg + MW'(2 ** 30);
    assign rnd = m_round[MW-1:31];
    assign rnd_s = $signed(FW'(rnd));
    assign phase_next = e_neg ? phase_reg - 32'(rnd) : phase_reg + 32'(rnd);
    assign f_sum = e_neg ? FW'(freq_reg) - rnd_s : FW'(freq_reg) + rnd_s;

    // Error magnitude doubled and saturated to 32 bits feeds the leaky average.
    assign e2 = {e_mag, 1'b0};
    assign ae32 = (e2 > (EW+1)'(33'h0_FFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(e2);
    assign ae_w = ae32 * POLE_Q20;
    assign avg_sum = 53'(avg_prod_reg) + 53'(ae_w) + 53'(2 ** 19);
    assign avg_shift = avg_sum[52:20];
    assign avg_next = avg_shift[32] ? 32'hFFFF_FFFF : avg_shift[31:0];

    assign lock_next = (!lock_reg && avg_reg < LOCK_ON_Q16) ? 1'b1 :
                       (lock_reg && avg_reg > LOCK_OFF_Q16) ? 1'b0 : lock_reg;

    assign lim_cap = (limit_reg > ONE_RAD_UNITS) ? ONE_RAD_UNITS : limit_reg;
    assign lim = oqpsk_reg ? (lim_cap >> 1) : lim_cap;
    assign lim_s = $signed(FW'(lim));
    assign f_clamped = (f_reg > lim_s) ? lim_s : ((f_reg < -lim_s) ? -lim_s : f_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= '0;
            beta_reg <= '0;
            limit_reg <= FREQ_LIMIT_RESET;
            oqpsk_reg <= 1'b0;
            phase_reg <= '0;
            freq_reg <= '0;
            avg_reg <= AVG_RESET;
            lock_reg <= 1'b0;
            seen_reg <= 1'b0;
            sweep_down_reg <= 1'b0;
            mixed_re_reg <= '0;
            mixed_im_reg <= '0;
            freq_out_reg <= '0;
            locked_reg <= 1'b0;
            locked_once_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_ALPHA: alpha_reg <= cfg_data;
                    CFG_BETA:  beta_reg <= cfg_data;
                    CFG_LIMIT: limit_reg <= cfg_data[30:0];
                    CFG_OQPSK: oqpsk_reg <= cfg_data[0];
                    default:   alpha_reg <= alpha_reg;
                endcase
            end
            case (cmd.op)
                OP_MFIN:
                begin
                    phase_reg <= phase_reg + freq_reg;
                    mixed_re_reg <= round_sat(acc_re_reg);
                    mixed_im_reg <= round_sat(acc_im_reg);
                    freq_out_reg <= freq_reg;
                    locked_reg <= lock_reg;
                    locked_once_reg <= seen_reg;
                end
                OP_PAPPLY: phase_reg <= phase_next;
                OP_AVG:    avg_reg <= avg_next;
                OP_LOCK:
                begin
                    lock_reg <= lock_next;
                    if (lock_next && !lock_reg)
                        seen_reg <= 1'b1;
                end
                OP_CLAMP:
                begin
                    if (f_reg >= lim_s)
                        sweep_down_reg <= 1'b1;
                    else if (f_reg <= -lim_s)
                        sweep_down_reg <= 1'b0;
                    freq_reg <= f_clamped[31:0];
                    mixed_re_reg <= '0;
                    mixed_im_reg <= '0;
                    freq_out_reg <= f_clamped[31:0];
                    locked_reg <= lock_reg;
                    locked_once_reg <= seen_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_input)
        begin
            re_reg <= sample_re;
            im_reg <= sample_im;
            cq_reg <= cosample_im;
        end
        case (cmd.op)
            OP_SIDX: idx_reg <= idx_prod[32 +: IW];
            OP_SRD:
            begin
                rom_q_reg <= SINE_ROM[idx_reg];
                idx_reg <= idx_prod[32 +: IW];
            end
            OP_CRD:
            begin
                s_reg <= rom_q_reg;
                rom_q_reg <= SINE_ROM[idx_reg];
            end
            OP_MRE1:
            begin
                c_reg <= rom_q_reg;
                acc_re_reg <= AW'(mul_a);
            end
            OP_MRE2: acc_re_reg <= acc_re_reg + AW'(mul_a);
            OP_MIM1: acc_im_reg <= AW'(mul_a);
            OP_MIM2: acc_im_reg <= acc_im_reg - AW'(mul_b);
            OP_TANH:
            begin
                t_re_reg <= tanh_of(re_reg);
                t_cq_reg <= tanh_of(cq_reg);
            end
            OP_ERR1: prod_reg <= mul_a;
            OP_ERR2: e_reg <= EW'(prod_reg) - EW'(mul_b);
            OP_PLO:    m_reg <= MW'(g_prod);
            OP_PHI:    m_reg <= m_reg + {g_prod, 16'b0};
            OP_PAPPLY: m_reg <= MW'(g_prod);
            OP_FHI:    m_reg <= m_reg + {g_prod, 16'b0};
            OP_FSUM:
            begin
                f_reg <= f_sum;
                avg_prod_reg <= avg_reg * POLE_KEEP_Q20;
            end
            OP_LOCK:
            begin
                if (!lock_next)
                    f_reg <= sweep_down_reg ? f_reg - FW'(SWEEP_STEP) : f_reg + FW'(SWEEP_STEP);
            end
            default: ;
        endcase
    end

    assign mixed_re = mixed_re_reg;
    assign mixed_im = mixed_im_reg;
    assign freq_estimate = freq_out_reg;
    assign locked = locked_reg;
    assign locked_once = locked_once_reg;

endmodule

// ===== hdl/qcrl_checker.sv =====
// Port-level checks of the carrier loop, attached to the top level by bind.
// Depends on qcrl_pkg for the one-radian frequency bound.
`timescale 1ns / 1ps

module qcrl_checker
    import qcrl_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] freq_estimate,
    input logic               locked,
    input logic               locked_once
);

    // An accepted item keeps the input side busy while its steps run.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall ##1 in_stall)
        else $error("input accepted again too soon");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(freq_estimate))
        else $error("stalled result changed");

    a_lock_implies_seen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && locked |-> locked_once)
        else $error("locked without sticky flag");

    a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        locked_once |=> locked_once)
        else $error("sticky lock flag cleared");

    a_freq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (freq_estimate <= $signed({1'b0, ONE_RAD_UNITS}))
                   && (freq_estimate >= -$signed({1'b0, ONE_RAD_UNITS})))
        else $error("frequency beyond one radian");

endmodule

bind qpsk_carrier_recovery_loop qcrl_checker u_qcrl_checker (.*);

// ===== sim/qpsk_carrier_recovery_loop_test.sv =====
// Self-checking testbench for the QPSK carrier recovery loop.
// It depends on qcrl_pkg for the opcode and register index names, and on the RTL top level.
`timescale 1ns / 1ps

module qpsk_carrier_recovery_loop_test;
    import qcrl_pkg::*;

    localparam int SINE_DEPTH = 1024;
    localparam longint MAX_LIMIT_UNITS = 683565276;
    localparam longint FREQ_STEP = 684;
    localparam longint KEEP_Q20 = (64'd1 << 20) - 64'd1049;
    localparam longint LOCK_ENTER = 85 * 65536;
    localparam longint LOCK_LEAVE = 105 * 65536;
    localparam int LONG_HOLD_CYCLES = 300;
    // Settling time after the last result before a register write or the end of the run.
    // It is ample for an update to pass from its transfer to its result.
    localparam int SETTLE_CYCLES = 30;

    localparam longint TANH_VALUES [32] = '{
        -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
        -32768, -32768, -32768, -32765, -32746, -32606, -31589, -24956,
        0, 24956, 31589, 32606, 32746, 32765, 32768, 32768,
        32768, 32768, 32768, 32768, 32768, 32768, 32768, 32768
    };

    typedef struct {
        logic              opc;
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic signed [15:0] cq;
    } sample_item_t;

    typedef struct {
        logic signed [15:0] mixed_re;
        logic signed [15:0] mixed_im;
        logic signed [31:0] freq;
        logic               lock_now;
        logic               lock_ever;
    } loop_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic opcode = OPC_MIX;
    logic signed [15:0] sample_re = '0;
    logic signed [15:0] sample_im = '0;
    logic signed [15:0] cosample_im = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [15:0] mixed_re;
    logic signed [15:0] mixed_im;
    logic signed [31:0] freq_estimate;
    logic locked;
    logic locked_once;
    logic cfg_write = 1'b0;
    logic [1:0] cfg_index = CFG_ALPHA;
    logic [31:0] cfg_data = '0;

    qpsk_carrier_recovery_loop u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .sample_re(sample_re), .sample_im(sample_im),
        .cosample_im(cosample_im),
        .out_valid(out_valid), .out_stall(out_stall),
        .mixed_re(mixed_re), .mixed_im(mixed_im), .freq_estimate(freq_estimate),
        .locked(locked), .locked_once(locked_once),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predicted loop state and register copies, advanced on every input transfer.
    longint sine_rom [SINE_DEPTH];
    logic [31:0] alpha_q16 = '0;
    logic [31:0] beta_q16 = '0;
    logic [30:0] limit_units = FREQ_LIMIT_RESET;
    logic        oqpsk_on = 1'b0;
    logic [31:0] phase_now = '0;
    logic signed [31:0] freq_now = '0;
    longint unsigned err_avg = 1000 * 65536;
    logic lock_now = 1'b0;
    logic lock_ever = 1'b0;
    logic sweeping_down = 1'b0;

    sample_item_t pending_items [$];
    loop_result_t expected_results [$];
    int mismatch_count = 0;
    int in_gap = 0;
    int out_gap = 0;
    int hold_count = 0;
    logic long_hold_req = 1'b0;
    logic quiet = 1'b0;

    initial begin
        forever #2 clk = ~clk;
    end

    // Sine table in Q15: a nested Taylor series in Q30 over one quadrant, mirrored
    // into the other three, rounded with ties upward.
    function automatic void fill_sine_rom();
        longint unsigned divs [5];
        longint unsigned u, quad, rem, x, x2, h, q;
        divs = '{110, 72, 42, 20, 6};
        for (int k = 0; k < SINE_DEPTH; k++) begin
            u = k * 4;
            quad = u / SINE_DEPTH;
            rem = u % SINE_DEPTH;
            x = rem * PI_HALF_Q30 / SINE_DEPTH;
            if (quad[0]) x = PI_HALF_Q30 - x;
            x2 = (x * x) >> 30;
            h = ONE_Q30;
            for (int i = 0; i < 5; i++)
                h = ONE_Q30 - ((x2 * h) >> 30) / divs[i];
            q = (((x * h) >> 30) + 16384) >> 15;
            sine_rom[k] = quad[1] ? -longint'(q) : longint'(q);
        end
    endfunction

    // Shift right by n with rounding half away from zero.
    function automatic longint round_away(longint v, int n);
        longint half;
        half = longint'(1) <<< (n - 1);
        if (v < 0)
            return -((-v + half) >>> n);
        return (v + half) >>> n;
    endfunction

    function automatic longint clip_sample(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint soft_decision(longint v);
        if (v > 15) return 32768;
        if (v < -16) return -32768;
        return TANH_VALUES[v + 16];
    endfunction

    // Advances the predicted loop by one transfer and returns the result it should give.
    function automatic loop_result_t advance_loop(sample_item_t it);
        loop_result_t r;
        longint re, im, cq, s, c, e, lim, f;
        longint unsigned mag, avg;
        logic [31:0] cos_phase;
        re = it.re;
        im = it.im;
        cq = it.cq;
        r.mixed_re = '0;
        r.mixed_im = '0;
        if (it.opc == OPC_MIX) begin
            cos_phase = phase_now + 32'h4000_0000;
            s = sine_rom[phase_now[31:22]];
            c = sine_rom[cos_phase[31:22]];
            r.mixed_re = 16'(clip_sample(round_away(re * c + im * s, 15)));
            r.mixed_im = 16'(clip_sample(round_away(im * c - re * s, 15)));
            phase_now = phase_now + freq_now;
        end else begin
            e = soft_decision(re) * cq - soft_decision(cq) * re;
            lim = longint'(limit_units);
            if (lim > MAX_LIMIT_UNITS) lim = MAX_LIMIT_UNITS;
            if (oqpsk_on) lim = lim >>> 1;
            phase_now = phase_now + 32'(round_away(longint'({32'd0, alpha_q16}) * e, 31));
            f = longint'(freq_now) + round_away(longint'({32'd0, beta_q16}) * e, 31);
            mag = (e < 0 ? -e : e) * 2;
            if (mag > 64'hFFFF_FFFF) mag = 64'hFFFF_FFFF;
            avg = (err_avg * KEEP_Q20 + mag * 1049 + (64'd1 << 19)) >> 20;
            err_avg = (avg > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : avg;
            // Lock detector with hysteresis; the sticky flag follows the first lock.
            if (err_avg < LOCK_ENTER && !lock_now) begin
                lock_now = 1'b1;
                lock_ever = 1'b1;
            end else if (err_avg > LOCK_LEAVE && lock_now) begin
                lock_now = 1'b0;
            end
            // Frequency search while unlocked, turning around at the limits.
            if (!lock_now) f = f + (sweeping_down ? -FREQ_STEP : FREQ_STEP);
            if (f >= lim) sweeping_down = 1'b1;
            else if (f <= -lim) sweeping_down = 1'b0;
            if (f > lim) f = lim;
            if (f < -lim) f = -lim;
            freq_now = 32'(f);
        end
        r.freq = freq_now;
        r.lock_now = lock_now;
        r.lock_ever = lock_ever;
        return r;
    endfunction

    // Sender: offers queued items, predicts each transfer as it happens, and inserts
    // random idle bursts unless the run is in its quiet tail.
    always @(posedge clk) begin
        sample_item_t nxt;
        sample_item_t cur;
        if (in_valid && !in_stall) begin
            cur.opc = opcode;
            cur.re = sample_re;
            cur.im = sample_im;
            cur.cq = cosample_im;
            expected_results.push_back(advance_loop(cur));
        end
        if (!in_valid || !in_stall) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                nxt = pending_items.pop_front();
                opcode <= nxt.opc;
                sample_re <= nxt.re;
                sample_im <= nxt.im;
                cosample_im <= nxt.cq;
                in_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0)
                    in_gap <= $urandom_range(1, 5);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: one long hold-off so the block backs up into its input, then
    // random bursts of stalled cycles.
    always @(posedge clk) begin
        if (long_hold_req && hold_count < LONG_HOLD_CYCLES) begin
            hold_count <= hold_count + 1;
            out_stall <= 1'b1;
        end else if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            out_gap <= $urandom_range(0, 4);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Checker: every result transfer is compared field by field with the oldest prediction.
    always @(posedge clk) begin
        loop_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                $display("%0t: unexpected result transfer, freq_estimate %0d",
                         $realtime, freq_estimate);
            end else begin
                want = expected_results.pop_front();
                if (mixed_re !== want.mixed_re || mixed_im !== want.mixed_im ||
                    freq_estimate !== want.freq || locked !== want.lock_now ||
                    locked_once !== want.lock_ever) begin
                    mismatch_count <= mismatch_count + 1;
                    $display("%0t: expected re %0d im %0d freq %0d lock %b once %b",
                             $realtime, want.mixed_re, want.mixed_im, want.freq,
                             want.lock_now, want.lock_ever);
                    $display("%0t: actual   re %0d im %0d freq %0d lock %b once %b",
                             $realtime, mixed_re, mixed_im, freq_estimate,
                             locked, locked_once);
                end
            end
        end
    end

    task automatic queue_item(logic opc, int re, int im, int cq);
        sample_item_t it;
        it.opc = opc;
        it.re = 16'(re);
        it.im = 16'(im);
        it.cq = 16'(cq);
        pending_items.push_back(it);
    endtask

    // Random item: half full-range values, a quarter small ones in and around the
    // tanh table range, and a quarter at the sample extremes.
    function automatic int pick_sample();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 40) - 20;
            1: return $urandom_range(0, 1) ? 32767 : -32768;
            default: return $urandom_range(0, 65535) - 32768;
        endcase
    endfunction

    task automatic queue_random(int count);
        for (int n = 0; n < count; n++)
            queue_item($urandom_range(0, 1) ? OPC_UPDATE : OPC_MIX,
                       pick_sample(), pick_sample(), pick_sample());
    endtask

    // Waits until all queued items have gone in and every prediction has been met.
    task automatic drain();
        while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write while the block is idle; the predictor masks bits the same way.
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_ALPHA: alpha_q16 = value;
            CFG_BETA:  beta_q16 = value;
            CFG_LIMIT: limit_units = value[30:0];
            CFG_OQPSK: oqpsk_on = value[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial begin
        fill_sine_rom();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: reset settings, field extremes for both operations, zero error,
        // largest error magnitudes, and tanh inputs just inside and outside the table.
        queue_item(OPC_MIX, 32767, 32767, 0);
        queue_item(OPC_MIX, -32768, -32768, 0);
        queue_item(OPC_MIX, -32768, 32767, -1);
        queue_item(OPC_MIX, 0, 0, 0);
        queue_item(OPC_UPDATE, 0, 0, 0);
        queue_item(OPC_UPDATE, -1, 0, 32767);
        queue_item(OPC_UPDATE, 32767, 0, -32768);
        queue_item(OPC_UPDATE, -32768, -1, 32767);
        queue_item(OPC_UPDATE, 15, 0, -16);
        queue_item(OPC_UPDATE, 16, 0, -17);
        queue_item(OPC_UPDATE, -16, 0, 15);
        queue_item(OPC_MIX, 12345, -23456, 0);
        drain();

        // Largest gains with the limit written with its unused top bit set, so it caps
        // at one radian, and offset mode written with its unused bits set.
        write_reg(CFG_ALPHA, 32'hFFFF_FFFF);
        write_reg(CFG_BETA, 32'hFFFF_FFFF);
        write_reg(CFG_LIMIT, 32'hFFFF_FFFF);
        write_reg(CFG_OQPSK, 32'hFFFF_FFFF);
        queue_item(OPC_UPDATE, -1, 0, 32767);
        queue_item(OPC_UPDATE, 1, 0, -32768);
        queue_item(OPC_MIX, 32767, -32768, 0);
        queue_item(OPC_UPDATE, 5, 0, -3);
        queue_item(OPC_MIX, -32768, 32767, 0);
        long_hold_req = 1'b1;
        queue_random(110);
        drain();

        // A run of zero errors pulls the average down, then large errors push it
        // back up while the frequency keeps sweeping.
        write_reg(CFG_OQPSK, 32'd0);
        write_reg(CFG_LIMIT, 32'd1000000);
        for (int n = 0; n < 120; n++) begin
            if (n % 50 == 0)
                queue_item(OPC_MIX, pick_sample(), pick_sample(), 0);
            else
                queue_item(OPC_UPDATE, 0, pick_sample(), 0);
        end
        for (int n = 0; n < 12; n++)
            queue_item(OPC_UPDATE, -1, 0, 32767);
        drain();

        // Zero limit: the frequency is pinned and the sweep turns on every update.
        write_reg(CFG_ALPHA, 32'd0);
        write_reg(CFG_BETA, 32'd0);
        write_reg(CFG_LIMIT, 32'd0);
        queue_random(90);
        drain();

        // Random gains with a small beta, and a random limit in offset mode.
        write_reg(CFG_ALPHA, $urandom);
        write_reg(CFG_BETA, $urandom_range(0, 32'h000F_FFFF));
        write_reg(CFG_LIMIT, $urandom);
        write_reg(CFG_OQPSK, 32'd1);
        queue_random(130);
        drain();

        // Quiet tail: no idling on either side.
        write_reg(CFG_ALPHA, $urandom);
        write_reg(CFG_BETA, $urandom);
        write_reg(CFG_LIMIT, 32'h7FFF_FFFF);
        write_reg(CFG_OQPSK, 32'd0);
        quiet = 1'b1;
        queue_random(110);
        drain();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/qcrl_pkg.sv
hdl/qcrl_ctrl.sv
hdl/qcrl_datapath.sv
hdl/qpsk_carrier_recovery_loop.sv
hdl/qcrl_checker.sv
sim/qpsk_carrier_recovery_loop_test.sv
